/* rtl/tcw_pkg.sv */
// Shared field widths, command codes and character constants for the text console writer.
package tcw_pkg;

   // Field widths fixed by the command and result formats
   localparam int CMD_W    = 2;
   localparam int CHAR_W   = 8;
   localparam int TCOL_W   = 7;
   localparam int TROW_W   = 5;
   localparam int CELL_W   = 16;
   localparam int COLOR_W  = 4;
   localparam int CSR_IX_W = 1;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_PUT  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SET  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP  = 2'd3;

   // Configuration register indexes
   localparam logic [CSR_IX_W-1:0] CSR_FG_COLOR = 1'b0;
   localparam logic [CSR_IX_W-1:0] CSR_BG_COLOR = 1'b1;

   // Character codes
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
   localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;

endpackage

/* rtl/tcw_screen_ram.sv */
// Screen cell store: one write port and one read port with registered read data.
module tcw_screen_ram
   import tcw_pkg::*;
#(
   parameter int DEPTH  = 2000,
   parameter int ADDR_W = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [CELL_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [CELL_W-1:0] rd_data
);

   logic [CELL_W-1:0] mem [DEPTH];
   logic [CELL_W-1:0] rd_data_ff;

   // Write the addressed cell
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Register the read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/text_console_writer_unit.sv */
// Text console writer: cursor control, screen store sequencing and result strobe.
// Put, newline, set cursor, unused and off-screen read commands give a result in the cycle
// after the transfer; an on-screen read registers the memory read data and then the result.
// One command per cycle while not busy; an on-screen read holds busy while it waits, and a
// pending-clear put sweeps the store, busy through the whole sweep, with the result after it.
// Synchronous reset homes the cursor and zeroes the colors; the store is not cleared.
module text_console_writer_unit
   import tcw_pkg::*;
#(
   parameter int SCREEN_COLS = 80,
   parameter int SCREEN_ROWS = 25
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [CHAR_W-1:0]   req_char_code,
   input  logic [TCOL_W-1:0]   req_target_col,
   input  logic [TROW_W-1:0]   req_target_row,
   output logic                rsp_valid,
   output logic [CELL_W-1:0]   rsp_cell_value,
   output logic [TCOL_W-1:0]   rsp_cursor_col,
   output logic [TROW_W-1:0]   rsp_cursor_row,
   output logic                rsp_screen_cleared,
   input  logic                csr_we,
   input  logic [CSR_IX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]  csr_wdata
);

   localparam int CELL_COUNT = SCREEN_COLS * SCREEN_ROWS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int COL_W      = $clog2(SCREEN_COLS);
   localparam int ROW_W      = $clog2(SCREEN_ROWS + 1);

   localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(SCREEN_COLS - 1);
   localparam logic [ROW_W-1:0]  PAST_ROW   = ROW_W'(SCREEN_ROWS);
   localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(CELL_COUNT - 1);
   localparam logic [ADDR_W-1:0] ADDR_COLS  = ADDR_W'(SCREEN_COLS);
   localparam logic [TCOL_W:0]   TCOL_LIMIT = (TCOL_W + 1)'(SCREEN_COLS);
   localparam logic [6:0]        TROW_LIMIT = 7'(SCREEN_ROWS);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CLEAR = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   line_ff, line_in;
   logic [ADDR_W-1:0]  sweep_ff, sweep_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic [COLOR_W-1:0] fg_ff, bg_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]  rsp_cell_ff, rsp_cell_in;
   logic [COL_W-1:0]   rsp_col_ff;
   logic [ROW_W-1:0]   rsp_row_ff;
   logic               rsp_cleared_ff, rsp_cleared_in;

   logic               accept;
   logic               wr_en, rd_en;
   logic [ADDR_W-1:0]  wr_addr, rd_addr, cur_addr;
   logic [CELL_W-1:0]  wr_data, rd_data, blank_cell, put_cell, sweep_cell;
   logic               tcol_ok, trow_ok;
   logic [COL_W-1:0]   adv_col;
   logic [ROW_W-1:0]   adv_line;
   logic [COL_W+TCOL_W-1:0] col_ext;
   logic [ROW_W+TROW_W-1:0] row_ext;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // Cell images and addresses
   assign blank_cell = {bg_ff, fg_ff, BLANK_CODE};
   assign put_cell   = {bg_ff, fg_ff, req_char_code};
   assign sweep_cell = (sweep_ff == '0) ? {bg_ff, fg_ff, char_ff} : blank_cell;
   assign cur_addr   = ADDR_W'(line_ff) * ADDR_COLS + ADDR_W'(col_ff);
   assign rd_addr    = ADDR_W'(req_target_row) * ADDR_COLS + ADDR_W'(req_target_col);
   assign tcol_ok    = ({1'b0, req_target_col} < TCOL_LIMIT);
   assign trow_ok    = ({2'b0, req_target_row} < TROW_LIMIT);

   // Cursor advance after a cell write, wrapping at the right edge
   assign adv_col  = (col_ff == LAST_COL) ? '0 : col_ff + COL_W'(1);
   assign adv_line = (col_ff == LAST_COL) ? line_ff + ROW_W'(1) : line_ff;

   // Sequence commands, the clear sweep and the read wait
   always_comb begin
      state_in       = state_ff;
      col_in         = col_ff;
      line_in        = line_ff;
      sweep_in       = sweep_ff;
      char_in        = char_ff;
      rsp_valid_in   = 1'b0;
      rsp_cell_in    = '0;
      rsp_cleared_in = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = cur_addr;
      wr_data        = put_cell;
      rd_en          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  CMD_PUT: begin
                     if (req_char_code == NEWLINE_CODE) begin
                        col_in       = '0;
                        rsp_valid_in = 1'b1;
                        if (line_ff < PAST_ROW) begin
                           line_in = line_ff + ROW_W'(1);
                        end
                     end else if (line_ff >= PAST_ROW) begin
                        state_in = ST_CLEAR;
                        sweep_in = LAST_ADDR;
                        char_in  = req_char_code;
                     end else begin
                        wr_en        = 1'b1;
                        col_in       = adv_col;
                        line_in      = adv_line;
                        rsp_cell_in  = put_cell;
                        rsp_valid_in = 1'b1;
                     end
                  end
                  CMD_SET: begin
                     col_in       = tcol_ok ? req_target_col[COL_W-1:0] : LAST_COL;
                     line_in      = trow_ok ? ROW_W'(req_target_row) : PAST_ROW;
                     rsp_valid_in = 1'b1;
                  end
                  CMD_READ: begin
                     if (tcol_ok && trow_ok) begin
                        rd_en    = 1'b1;
                        state_in = ST_READ;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            // Sweep downward; the last cell written is the home cell with the character
            wr_en   = 1'b1;
            wr_addr = sweep_ff;
            wr_data = sweep_cell;
            if (sweep_ff == '0) begin
               col_in         = COL_W'(1);
               line_in        = '0;
               rsp_cell_in    = sweep_cell;
               rsp_cleared_in = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               sweep_in = sweep_ff - ADDR_W'(1);
            end
         end
         ST_READ: begin
            rsp_cell_in  = rd_data;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         line_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         line_ff      <= line_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Color registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= '0;
         bg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FG_COLOR: fg_ff <= csr_wdata;
            CSR_BG_COLOR: bg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      sweep_ff       <= sweep_in;
      char_ff        <= char_in;
      rsp_cell_ff    <= rsp_cell_in;
      rsp_col_ff     <= col_in;
      rsp_row_ff     <= line_in;
      rsp_cleared_ff <= rsp_cleared_in;
   end

   tcw_screen_ram #(
      .DEPTH  (CELL_COUNT),
      .ADDR_W (ADDR_W)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Fit cursor values to the result field widths
   assign col_ext = {{TCOL_W{1'b0}}, rsp_col_ff};
   assign row_ext = {{TROW_W{1'b0}}, rsp_row_ff};

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cell_value     = rsp_cell_ff;
   assign rsp_cursor_col     = col_ext[TCOL_W-1:0];
   assign rsp_cursor_row     = row_ext[TROW_W-1:0];
   assign rsp_screen_cleared = rsp_cleared_ff;

   // Checks
   a_read_wait_responds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> rsp_valid)
      else $error("read wait did not produce a result");

   a_set_responds: assert property (@(posedge clock) disable iff (reset)
      accept && req_cmd == CMD_SET |=> rsp_valid && !rsp_screen_cleared)
      else $error("set cursor result missing or marked as clear");

   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while still busy");

   a_cursor_bounds: assert property (@(posedge clock) disable iff (reset)
      line_ff <= PAST_ROW && col_ff <= LAST_COL)
      else $error("cursor out of bounds");

endmodule
